@@ design/mvsg_pkg.sv @@
// Shared types, codes and constants for the MPEG video segment gate.
package mvsg_pkg;

    // Input action codes; the last one is ignored
    localparam logic [1:0] ACT_DATA   = 2'd0;
    localparam logic [1:0] ACT_FLUSH  = 2'd1;
    localparam logic [1:0] ACT_EOS    = 2'd2;
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    // Start-code values after 00 00 01
    localparam logic [7:0] CODE_PICTURE    = 8'h00;
    localparam logic [7:0] CODE_SEQ_HEADER = 8'hB3;
    localparam logic [7:0] CODE_SEQ_END    = 8'hB7;
    localparam logic [7:0] PREFIX_ZERO     = 8'h00;
    localparam logic [7:0] PREFIX_ONE      = 8'h01;

    localparam int unsigned STAMP_W = 32;

    typedef enum logic [2:0] {
        V_NONE           = 3'd0,
        V_COMMIT_BEFORE  = 3'd1,
        V_DROP_BEFORE    = 3'd2,
        V_COMMIT_THROUGH = 3'd3,
        V_DROP_THROUGH   = 3'd4
    } t_verdict;

    typedef enum logic [1:0] {
        SC_WAIT_ZERO = 2'd0,
        SC_ONE_ZERO  = 2'd1,
        SC_TWO_ZERO  = 2'd2,
        SC_CODE      = 2'd3
    } t_scan_phase;

    typedef enum logic [1:0] {
        PH_WAIT    = 2'd0,
        PH_START   = 2'd1,
        PH_PICTURE = 2'd2
    } t_parse_phase;

    typedef struct packed {
        logic [1:0]         action;
        logic [7:0]         data_byte;
        logic               chunk_last;
        logic [STAMP_W-1:0] chunk_stamp;
        logic               chunk_stamp_valid;
    } t_item;

    typedef struct packed {
        t_verdict           verdict;
        logic [STAMP_W-1:0] pts_out;
        logic               pts_out_valid;
        logic               append_end_code;
    } t_result;

endpackage

@@ design/mpeg_video_segment_gate_unit.sv @@
// Top level of the MPEG video segment gate: input register, parser, result register.
// The input register takes an item at the edge that accepts it; the result register
//   then loads its result once free. The parser state update is a single short pass.
// Throughput: one item per cycle unless the receiver stalls.
// Reset: synchronous, active low; clears both pipeline valids and the parser state
//   (scanner waiting for zero, parser waiting for sequence, no stamp, nothing pending).
module mpeg_video_segment_gate_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_action,
    input  logic [7:0]  i_data_byte,
    input  logic        i_chunk_last,
    input  logic [31:0] i_chunk_stamp,
    input  logic        i_chunk_stamp_valid,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_verdict,
    output logic [31:0] o_pts_out,
    output logic        o_pts_out_valid,
    output logic        o_append_end_code
);

    logic              r_in_valid;
    mvsg_pkg::t_item   r_in;
    logic              r_out_valid;
    mvsg_pkg::t_result r_out;
    mvsg_pkg::t_result step_res;
    logic              advance;
    logic              in_take;

    // Pipeline control: result register frees when empty or being taken
    assign advance = !r_out_valid || !i_stall;
    assign o_stall = r_in_valid && !advance;
    assign in_take = i_valid && !o_stall;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (advance || !r_in_valid) begin
            r_in_valid <= in_take;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in.action            <= i_action;
            r_in.data_byte         <= i_data_byte;
            r_in.chunk_last        <= i_chunk_last;
            r_in.chunk_stamp       <= i_chunk_stamp;
            r_in.chunk_stamp_valid <= i_chunk_stamp_valid;
        end
    end

    mvsg_parser u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (r_in_valid && advance),
        .i_item  (r_in),
        .o_res   (step_res)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in_valid) begin
            r_out <= step_res;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_verdict         = r_out.verdict;
    assign o_pts_out         = r_out.pts_out;
    assign o_pts_out_valid   = r_out.pts_out_valid;
    assign o_append_end_code = r_out.append_end_code;

endmodule

@@ design/mvsg_parser.sv @@
// Start-code scanner, sequence parser state and per-item verdict logic.
module mvsg_parser (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_step,
    input  mvsg_pkg::t_item i_item,
    output mvsg_pkg::t_result o_res
);

    mvsg_pkg::t_scan_phase  r_scan, n_scan;
    mvsg_pkg::t_parse_phase r_phase, n_phase;
    logic [mvsg_pkg::STAMP_W-1:0] r_stamp, n_stamp;
    logic r_stamp_valid, n_stamp_valid;
    logic r_pending, n_pending;

    // Byte decode
    logic is_data, is_flush, is_eos;
    logic is_hdr, is_end, is_pic, have_code;
    mvsg_pkg::t_scan_phase  scan_step;
    mvsg_pkg::t_parse_phase phase_code;
    mvsg_pkg::t_verdict     code_verdict, data_verdict;
    logic code_pts, chunk_drop;

    assign is_data   = (i_item.action == mvsg_pkg::ACT_DATA);
    assign is_flush  = (i_item.action == mvsg_pkg::ACT_FLUSH);
    assign is_eos    = (i_item.action == mvsg_pkg::ACT_EOS);
    assign is_hdr    = (i_item.data_byte == mvsg_pkg::CODE_SEQ_HEADER);
    assign is_end    = (i_item.data_byte == mvsg_pkg::CODE_SEQ_END);
    assign is_pic    = (i_item.data_byte == mvsg_pkg::CODE_PICTURE);
    assign have_code = (r_scan == mvsg_pkg::SC_CODE);

    // Scanner advance for a data byte
    always_comb begin
        case (r_scan)
            mvsg_pkg::SC_WAIT_ZERO: begin
                scan_step = (i_item.data_byte == mvsg_pkg::PREFIX_ZERO) ?
                            mvsg_pkg::SC_ONE_ZERO : mvsg_pkg::SC_WAIT_ZERO;
            end
            mvsg_pkg::SC_ONE_ZERO: begin
                scan_step = (i_item.data_byte == mvsg_pkg::PREFIX_ZERO) ?
                            mvsg_pkg::SC_TWO_ZERO : mvsg_pkg::SC_WAIT_ZERO;
            end
            mvsg_pkg::SC_TWO_ZERO: begin
                if (i_item.data_byte == mvsg_pkg::PREFIX_ONE)
                    scan_step = mvsg_pkg::SC_CODE;
                else if (i_item.data_byte == mvsg_pkg::PREFIX_ZERO)
                    scan_step = mvsg_pkg::SC_TWO_ZERO;
                else
                    scan_step = mvsg_pkg::SC_WAIT_ZERO;
            end
            default: scan_step = mvsg_pkg::SC_WAIT_ZERO;
        endcase
    end

    // Parser reaction to a start code; unknown phase acts as waiting
    always_comb begin
        code_verdict = mvsg_pkg::V_NONE;
        phase_code   = r_phase;
        code_pts     = 1'b0;
        if (have_code) begin
            case (r_phase)
                mvsg_pkg::PH_START: begin
                    if (is_hdr) begin
                        code_verdict = mvsg_pkg::V_DROP_BEFORE;
                    end else if (is_end) begin
                        code_verdict = mvsg_pkg::V_DROP_THROUGH;
                        phase_code   = mvsg_pkg::PH_WAIT;
                    end else if (is_pic) begin
                        phase_code   = mvsg_pkg::PH_PICTURE;
                    end
                end
                mvsg_pkg::PH_PICTURE: begin
                    if (is_end) begin
                        code_verdict = mvsg_pkg::V_COMMIT_THROUGH;
                        phase_code   = mvsg_pkg::PH_WAIT;
                        code_pts     = 1'b1;
                    end else if (is_hdr) begin
                        code_verdict = mvsg_pkg::V_COMMIT_BEFORE;
                        phase_code   = mvsg_pkg::PH_START;
                        code_pts     = 1'b1;
                    end else if (is_pic) begin
                        code_verdict = mvsg_pkg::V_COMMIT_BEFORE;
                        code_pts     = 1'b1;
                    end
                end
                default: begin
                    if (is_hdr) begin
                        code_verdict = mvsg_pkg::V_DROP_BEFORE;
                        phase_code   = mvsg_pkg::PH_START;
                    end
                end
            endcase
        end
    end

    // Chunk end while waiting drops all pending bytes
    assign chunk_drop = (code_verdict == mvsg_pkg::V_NONE) && i_item.chunk_last &&
                        (phase_code != mvsg_pkg::PH_START) &&
                        (phase_code != mvsg_pkg::PH_PICTURE);
    assign data_verdict = chunk_drop ? mvsg_pkg::V_DROP_THROUGH : code_verdict;

    // Result for the current item
    always_comb begin
        o_res = '0;
        o_res.verdict = mvsg_pkg::V_NONE;
        case (i_item.action)
            mvsg_pkg::ACT_DATA: begin
                o_res.verdict = data_verdict;
                if (code_pts) begin
                    o_res.pts_out       = r_stamp;
                    o_res.pts_out_valid = r_stamp_valid;
                end
            end
            mvsg_pkg::ACT_FLUSH: begin
                if (r_pending)
                    o_res.verdict = mvsg_pkg::V_DROP_THROUGH;
            end
            mvsg_pkg::ACT_EOS: begin
                o_res.append_end_code = 1'b1;
                if (r_pending) begin
                    o_res.verdict       = mvsg_pkg::V_COMMIT_THROUGH;
                    o_res.pts_out       = r_stamp;
                    o_res.pts_out_valid = r_stamp_valid;
                end
            end
            default: o_res.verdict = mvsg_pkg::V_NONE;
        endcase
    end

    // Next state
    always_comb begin
        n_scan        = r_scan;
        n_phase       = r_phase;
        n_stamp       = r_stamp;
        n_stamp_valid = r_stamp_valid;
        n_pending     = r_pending;
        if (is_data) begin
            n_phase   = phase_code;
            n_scan    = chunk_drop ? mvsg_pkg::SC_WAIT_ZERO : scan_step;
            n_pending = !((data_verdict == mvsg_pkg::V_COMMIT_THROUGH) ||
                          (data_verdict == mvsg_pkg::V_DROP_THROUGH));
            if (have_code && is_hdr) begin
                n_stamp_valid = i_item.chunk_stamp_valid;
                n_stamp       = i_item.chunk_stamp_valid ? i_item.chunk_stamp : '0;
            end else if ((code_verdict != mvsg_pkg::V_NONE) || chunk_drop) begin
                n_stamp_valid = 1'b0;
                n_stamp       = '0;
            end
        end else if (is_flush) begin
            n_scan        = mvsg_pkg::SC_WAIT_ZERO;
            n_phase       = mvsg_pkg::PH_WAIT;
            n_stamp       = '0;
            n_stamp_valid = 1'b0;
            n_pending     = 1'b0;
        end else if (is_eos && r_pending) begin
            n_scan        = mvsg_pkg::SC_WAIT_ZERO;
            n_stamp       = '0;
            n_stamp_valid = 1'b0;
            n_pending     = 1'b0;
        end
    end

    // State registers, updated once per processed item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan        <= mvsg_pkg::SC_WAIT_ZERO;
            r_phase       <= mvsg_pkg::PH_WAIT;
            r_stamp       <= '0;
            r_stamp_valid <= 1'b0;
            r_pending     <= 1'b0;
        end else if (i_step) begin
            r_scan        <= n_scan;
            r_phase       <= n_phase;
            r_stamp       <= n_stamp;
            r_stamp_valid <= n_stamp_valid;
            r_pending     <= n_pending;
        end
    end

endmodule

@@ design/mvsg_checker.sv @@
// Port-level checker for the MPEG video segment gate, bound to the top level.
module mvsg_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_stall,
    input logic [2:0]  o_verdict,
    input logic [31:0] o_pts_out,
    input logic        o_pts_out_valid,
    input logic        o_append_end_code
);

    // A stamp travels only with a commit
    a_pts_on_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_pts_out_valid) |->
            (o_verdict == mvsg_pkg::V_COMMIT_BEFORE ||
             o_verdict == mvsg_pkg::V_COMMIT_THROUGH))
        else $error("pts valid without a commit verdict");

    // Invalid stamps are carried as zero
    a_pts_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_pts_out_valid) |-> (o_pts_out == '0))
        else $error("pts nonzero while not valid");

    // End of stream either commits everything or has nothing pending
    a_eos_verdict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_append_end_code) |->
            (o_verdict == mvsg_pkg::V_NONE ||
             o_verdict == mvsg_pkg::V_COMMIT_THROUGH))
        else $error("end code request with a wrong verdict");

    // A stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=>
            (o_valid && $stable(o_verdict) && $stable(o_pts_out) &&
             $stable(o_pts_out_valid) && $stable(o_append_end_code)))
        else $error("stalled result changed");

endmodule

bind mpeg_video_segment_gate_unit mvsg_checker u_mvsg_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .o_valid           (o_valid),
    .i_stall           (i_stall),
    .o_verdict         (o_verdict),
    .o_pts_out         (o_pts_out),
    .o_pts_out_valid   (o_pts_out_valid),
    .o_append_end_code (o_append_end_code)
);

@@ verif/testbench.sv @@
// Self-checking testbench for the MPEG video segment gate: directed, random and backpressure runs.
`timescale 1ns / 1ps

module testbench;

    localparam int unsigned CYCLE_LIMIT = 300000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [1:0]  i_action = mvsg_pkg::ACT_DATA;
    logic [7:0]  i_data_byte = 8'h00;
    logic        i_chunk_last = 1'b0;
    logic [31:0] i_chunk_stamp = 32'h0;
    logic        i_chunk_stamp_valid = 1'b0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [2:0]  o_verdict;
    logic [31:0] o_pts_out;
    logic        o_pts_out_valid;
    logic        o_append_end_code;

    mpeg_video_segment_gate_unit dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_stall            (o_stall),
        .i_action           (i_action),
        .i_data_byte        (i_data_byte),
        .i_chunk_last       (i_chunk_last),
        .i_chunk_stamp      (i_chunk_stamp),
        .i_chunk_stamp_valid(i_chunk_stamp_valid),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_verdict          (o_verdict),
        .o_pts_out          (o_pts_out),
        .o_pts_out_valid    (o_pts_out_valid),
        .o_append_end_code  (o_append_end_code)
    );

    // 8 ns clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Idling controls and bookkeeping
    int unsigned send_gap_max = 0;
    int unsigned recv_gap_max = 0;
    int unsigned stall_left   = 0;
    int unsigned long_hold    = 0;
    int unsigned err_count    = 0;
    int unsigned cycle_count  = 0;

    mvsg_pkg::t_result verdict_queue[$];

    // Predicted parser state
    mvsg_pkg::t_scan_phase  scan_st;
    mvsg_pkg::t_parse_phase parse_st;
    logic [31:0]            held_pts;
    logic                   held_pts_ok;
    logic                   seg_pending;

    function automatic void reset_predictor();
        scan_st     = mvsg_pkg::SC_WAIT_ZERO;
        parse_st    = mvsg_pkg::PH_WAIT;
        held_pts    = 32'h0;
        held_pts_ok = 1'b0;
        seg_pending = 1'b0;
    endfunction

    // Segment leaves the buffer: scanner restarts, stamp cleared
    function automatic void close_segment();
        scan_st     = mvsg_pkg::SC_WAIT_ZERO;
        held_pts    = 32'h0;
        held_pts_ok = 1'b0;
    endfunction

    // Invalid stamps are held as zero
    function automatic void take_stamp(input logic [31:0] stamp, input logic ok);
        held_pts_ok = ok;
        held_pts    = ok ? stamp : 32'h0;
    endfunction

    // Next verdict for one accepted item; updates the predicted state
    function automatic mvsg_pkg::t_result predict_verdict(input mvsg_pkg::t_item it);
        mvsg_pkg::t_result r;
        logic              have_code;
        r = '0;
        have_code = 1'b0;
        case (it.action)
            mvsg_pkg::ACT_FLUSH: begin
                if (seg_pending)
                    r.verdict = mvsg_pkg::V_DROP_THROUGH;
                reset_predictor();
            end
            mvsg_pkg::ACT_EOS: begin
                r.append_end_code = 1'b1;
                if (seg_pending) begin
                    r.verdict       = mvsg_pkg::V_COMMIT_THROUGH;
                    r.pts_out       = held_pts;
                    r.pts_out_valid = held_pts_ok;
                    close_segment();
                    seg_pending = 1'b0;
                end
            end
            mvsg_pkg::ACT_DATA: begin
                seg_pending = 1'b1;
                // start-code scanner
                case (scan_st)
                    mvsg_pkg::SC_WAIT_ZERO: begin
                        if (it.data_byte == mvsg_pkg::PREFIX_ZERO)
                            scan_st = mvsg_pkg::SC_ONE_ZERO;
                    end
                    mvsg_pkg::SC_ONE_ZERO: begin
                        if (it.data_byte == mvsg_pkg::PREFIX_ZERO)
                            scan_st = mvsg_pkg::SC_TWO_ZERO;
                        else
                            scan_st = mvsg_pkg::SC_WAIT_ZERO;
                    end
                    mvsg_pkg::SC_TWO_ZERO: begin
                        if (it.data_byte == mvsg_pkg::PREFIX_ONE)
                            scan_st = mvsg_pkg::SC_CODE;
                        else if (it.data_byte != mvsg_pkg::PREFIX_ZERO)
                            scan_st = mvsg_pkg::SC_WAIT_ZERO;
                    end
                    default: begin
                        scan_st   = mvsg_pkg::SC_WAIT_ZERO;
                        have_code = 1'b1;
                    end
                endcase
                // sequence parser
                if (have_code) begin
                    if (parse_st == mvsg_pkg::PH_START) begin
                        if (it.data_byte == mvsg_pkg::CODE_SEQ_HEADER) begin
                            r.verdict = mvsg_pkg::V_DROP_BEFORE;
                            close_segment();
                            take_stamp(it.chunk_stamp, it.chunk_stamp_valid);
                        end else if (it.data_byte == mvsg_pkg::CODE_SEQ_END) begin
                            r.verdict = mvsg_pkg::V_DROP_THROUGH;
                            close_segment();
                            parse_st = mvsg_pkg::PH_WAIT;
                        end else if (it.data_byte == mvsg_pkg::CODE_PICTURE) begin
                            parse_st = mvsg_pkg::PH_PICTURE;
                        end
                    end else if (parse_st == mvsg_pkg::PH_PICTURE) begin
                        if (it.data_byte == mvsg_pkg::CODE_SEQ_HEADER ||
                            it.data_byte == mvsg_pkg::CODE_PICTURE ||
                            it.data_byte == mvsg_pkg::CODE_SEQ_END) begin
                            r.pts_out       = held_pts;
                            r.pts_out_valid = held_pts_ok;
                            close_segment();
                            if (it.data_byte == mvsg_pkg::CODE_SEQ_END) begin
                                r.verdict = mvsg_pkg::V_COMMIT_THROUGH;
                                parse_st  = mvsg_pkg::PH_WAIT;
                            end else begin
                                r.verdict = mvsg_pkg::V_COMMIT_BEFORE;
                                if (it.data_byte == mvsg_pkg::CODE_SEQ_HEADER) begin
                                    parse_st = mvsg_pkg::PH_START;
                                    take_stamp(it.chunk_stamp, it.chunk_stamp_valid);
                                end
                            end
                        end
                    end else begin
                        if (it.data_byte == mvsg_pkg::CODE_SEQ_HEADER) begin
                            r.verdict = mvsg_pkg::V_DROP_BEFORE;
                            close_segment();
                            parse_st = mvsg_pkg::PH_START;
                            take_stamp(it.chunk_stamp, it.chunk_stamp_valid);
                        end
                    end
                end
                if (r.verdict == mvsg_pkg::V_COMMIT_THROUGH ||
                    r.verdict == mvsg_pkg::V_DROP_THROUGH)
                    seg_pending = 1'b0;
                // chunk end while waiting for a sequence drops everything
                if (r.verdict == mvsg_pkg::V_NONE && it.chunk_last &&
                    parse_st != mvsg_pkg::PH_START && parse_st != mvsg_pkg::PH_PICTURE) begin
                    r.verdict = mvsg_pkg::V_DROP_THROUGH;
                    close_segment();
                    seg_pending = 1'b0;
                end
            end
            default: ;  // unused action: all-zero result, state kept
        endcase
        return r;
    endfunction

    // Send one item: random idle gap, then hold until accepted
    task automatic send_item(input mvsg_pkg::t_item it);
        int unsigned gap;
        gap = (send_gap_max == 0) ? 0 : $urandom_range(send_gap_max, 0);
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid             <= 1'b1;
        i_action            <= it.action;
        i_data_byte         <= it.data_byte;
        i_chunk_last        <= it.chunk_last;
        i_chunk_stamp       <= it.chunk_stamp;
        i_chunk_stamp_valid <= it.chunk_stamp_valid;
        do @(posedge i_clk); while (o_stall);
        verdict_queue.push_back(predict_verdict(it));
    endtask

    function automatic logic [31:0] rand_stamp();
        case ($urandom_range(7, 0))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    function automatic mvsg_pkg::t_item make_item(input logic [1:0] action,
                                                  input logic [7:0] b,
                                                  input logic last,
                                                  input logic [31:0] stamp,
                                                  input logic ok);
        mvsg_pkg::t_item it;
        it.action            = action;
        it.data_byte         = b;
        it.chunk_last        = last;
        it.chunk_stamp       = stamp;
        it.chunk_stamp_valid = ok;
        return it;
    endfunction

    // Data byte with random side fields; chunk end about one in six
    function automatic mvsg_pkg::t_item rand_data(input logic [7:0] b);
        return make_item(mvsg_pkg::ACT_DATA, b, ($urandom_range(5, 0) == 0), rand_stamp(),
                         1'($urandom_range(1, 0)));
    endfunction

    // 00 00 01 code; the stamp fields matter on the code byte
    task automatic send_code(input logic [7:0] code, input logic [31:0] stamp,
                             input logic ok, input logic last);
        send_item(make_item(mvsg_pkg::ACT_DATA, mvsg_pkg::PREFIX_ZERO, 1'b0, stamp, ok));
        send_item(make_item(mvsg_pkg::ACT_DATA, mvsg_pkg::PREFIX_ZERO, 1'b0, stamp, ok));
        send_item(make_item(mvsg_pkg::ACT_DATA, mvsg_pkg::PREFIX_ONE, 1'b0, stamp, ok));
        send_item(make_item(mvsg_pkg::ACT_DATA, code, last, stamp, ok));
    endtask

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            err_count++;
            $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
        end
    endfunction

    // Result checker; draws the receiver's wait after each item
    always @(posedge i_clk) begin : result_check
        mvsg_pkg::t_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (verdict_queue.size() == 0) begin
                err_count++;
                $display("%0t: unexpected result: expected none, actual verdict %h",
                         $time, o_verdict);
            end else begin
                want = verdict_queue.pop_front();
                check_field("verdict", 32'(want.verdict), 32'(o_verdict));
                check_field("pts_out", want.pts_out, o_pts_out);
                check_field("pts_out_valid", 32'(want.pts_out_valid), 32'(o_pts_out_valid));
                check_field("append_end_code", 32'(want.append_end_code),
                            32'(o_append_end_code));
            end
            stall_left = (recv_gap_max == 0) ? 0 : $urandom_range(recv_gap_max, 0);
        end
    end

    // Receiver stall driver; long hold counted here
    initial begin
        forever begin
            @(negedge i_clk);
            if (long_hold > 0) begin
                i_stall <= 1'b1;
                long_hold--;
            end else if (stall_left > 0) begin
                i_stall <= 1'b1;
                stall_left--;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Every action, stamp extremes, chunk end while waiting, flush and end of stream
    task automatic test_directed();
        send_gap_max = 3;
        recv_gap_max = 3;
        send_item(make_item(mvsg_pkg::ACT_UNUSED, 8'hFF, 1'b1, 32'hFFFF_FFFF, 1'b1)); // ignored
        send_item(make_item(mvsg_pkg::ACT_EOS, 8'h00, 1'b0, 32'h0, 1'b0));  // nothing pending
        send_code(mvsg_pkg::CODE_SEQ_HEADER, 32'hFFFF_FFFF, 1'b1, 1'b0);    // drop before
        send_code(mvsg_pkg::CODE_PICTURE, 32'h1234_5678, 1'b1, 1'b0);       // picture seen
        send_code(mvsg_pkg::CODE_SEQ_HEADER, 32'hFFFF_0000, 1'b0, 1'b0);    // commit, bad stamp
        send_code(mvsg_pkg::CODE_PICTURE, 32'h0, 1'b0, 1'b0);
        send_code(mvsg_pkg::CODE_SEQ_END, 32'h0, 1'b1, 1'b0);               // commit through
        send_item(make_item(mvsg_pkg::ACT_DATA, 8'hFF, 1'b1, 32'h0, 1'b0)); // chunk end, waiting
        send_item(make_item(mvsg_pkg::ACT_DATA, 8'h12, 1'b0, 32'h0, 1'b0));
        send_item(make_item(mvsg_pkg::ACT_EOS, 8'h00, 1'b0, 32'h0, 1'b0));  // eos commit
        send_item(make_item(mvsg_pkg::ACT_DATA, 8'h34, 1'b0, 32'h0, 1'b0));
        send_item(make_item(mvsg_pkg::ACT_FLUSH, 8'h00, 1'b0, 32'h0, 1'b0)); // flush drops
        send_item(make_item(mvsg_pkg::ACT_FLUSH, 8'h00, 1'b0, 32'h0, 1'b0)); // flush, empty
    endtask

    // Mostly well-formed streams with random content, plus noise and broken prefixes
    task automatic test_random_streams(input int unsigned n_items);
        int unsigned sent;
        int unsigned kind;
        int unsigned n;
        int unsigned next_switch;
        logic [7:0]  code;
        sent = 0;
        next_switch = 0;
        while (sent < n_items) begin
            if (sent >= next_switch) begin
                next_switch = sent + 150;
                case ($urandom_range(3, 0))
                    0: begin send_gap_max = 0;  recv_gap_max = 0;  end
                    1: begin send_gap_max = 15; recv_gap_max = 15; end
                    2: begin send_gap_max = 0;  recv_gap_max = 15; end
                    default: begin send_gap_max = 15; recv_gap_max = 0; end
                endcase
            end
            kind = $urandom_range(99, 0);
            if (kind < 70) begin
                n = $urandom_range(6, 0);
                repeat (n) send_item(rand_data(8'($urandom_range(255, 0))));
                case ($urandom_range(19, 0))
                    0, 1, 2, 3, 4, 5, 6, 7: code = mvsg_pkg::CODE_SEQ_HEADER;
                    8, 9, 10, 11, 12, 13, 14: code = mvsg_pkg::CODE_PICTURE;
                    15, 16, 17: code = mvsg_pkg::CODE_SEQ_END;
                    default: code = 8'($urandom_range(255, 0));
                endcase
                send_code(code, rand_stamp(), 1'($urandom_range(1, 0)),
                          ($urandom_range(7, 0) == 0));
                sent += n + 4;
            end else if (kind < 80) begin
                // broken prefix: zeros, then anything
                n = $urandom_range(3, 1);
                repeat (n) send_item(rand_data(mvsg_pkg::PREFIX_ZERO));
                send_item(rand_data($urandom_range(1, 0) ? mvsg_pkg::PREFIX_ONE :
                                    8'($urandom)));
                sent += n + 1;
            end else if (kind < 87) begin
                send_item(make_item(mvsg_pkg::ACT_FLUSH, 8'($urandom),
                                    1'($urandom_range(1, 0)), $urandom,
                                    1'($urandom_range(1, 0))));
                sent++;
            end else if (kind < 95) begin
                send_item(make_item(mvsg_pkg::ACT_EOS, 8'($urandom),
                                    1'($urandom_range(1, 0)), $urandom,
                                    1'($urandom_range(1, 0))));
                sent++;
            end else if (kind < 97) begin
                send_item(make_item(mvsg_pkg::ACT_UNUSED, 8'($urandom),
                                    1'($urandom_range(1, 0)), $urandom,
                                    1'($urandom_range(1, 0))));
            end else begin
                send_item(rand_data(8'($urandom_range(255, 0))));
                sent++;
            end
        end
    endtask

    // Receiver holds off while the sender keeps offering items
    task automatic test_backpressure();
        send_gap_max = 0;
        recv_gap_max = 0;
        long_hold = 400;
        repeat (20) send_code(mvsg_pkg::CODE_SEQ_HEADER, rand_stamp(),
                              1'($urandom_range(1, 0)), 1'b0);
        while (long_hold > 0) @(posedge i_clk);
        recv_gap_max = 7;
        repeat (10) begin
            send_code(mvsg_pkg::CODE_PICTURE, rand_stamp(), 1'b1, 1'b0);
            send_item(rand_data(8'($urandom_range(255, 2))));
        end
    endtask

    initial begin
        reset_predictor();
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_random_streams(1200);
        test_backpressure();

        @(negedge i_clk);
        i_valid <= 1'b0;
        while (verdict_queue.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        if (err_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
